// ===== hdl/packed_track_pattern_unpacker_macros.svh =====
// ----------------------------------------------------------------------------
// packed track pattern unpacker assertion macros
// concurrent check helpers on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PACKED_TRACK_PATTERN_UNPACKER_MACROS_SVH
`define PACKED_TRACK_PATTERN_UNPACKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PTPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptpu check failed");
// next-cycle implication
`define PTPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptpu check failed");
`else
`define PTPU_ASSERT_IMP(lbl, ante, cons)
`define PTPU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/ptpu_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpu_pkg
// shared constants and types of the packed track pattern unpacker
// ----------------------------------------------------------------------------
`default_nettype none

package ptpu_pkg;

	// geometry
	localparam int MAX_PATTERNS_DEF = 64;
	localparam int ROWS_PER_TRACK   = 64;
	localparam int ROW_W            = 6;
	localparam int VOICES           = 4;
	localparam int VOICE_W          = 2;

	// field and register widths
	localparam int WORD_W    = 32;
	localparam int PAT_W     = 7;
	localparam int OUT_PAT_W = 6;
	localparam int CNT_W     = 7;
	localparam int TW_W      = 9;
	localparam int SRC_W     = 14;

	// apb port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_PATTERN_COUNT = '0;

	// word decode
	localparam logic [15:0] HI_COPY    = 16'hC000;
	localparam logic [15:0] HI_RUN_MIN = 16'h8000;
	localparam logic [TW_W-1:0] TW_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_COPY
	} ptpu_state_t;

endpackage

`default_nettype wire

// ===== hdl/ptpu_ram.sv =====
// ----------------------------------------------------------------------------
// ptpu_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ptpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/packed_track_pattern_unpacker.sv =====
// ----------------------------------------------------------------------------
// packed_track_pattern_unpacker
// expands packed pattern words into note cells and keeps every track in a store
// ----------------------------------------------------------------------------
// Each accepted word is expanded into cells that leave one per cycle, while
// out_stall is low, through an output register: a note word gives one cell,
// an empty-row run gives its row count (clipped at the track end), a track
// copy gives the rest of the current track. A new word is taken only after
// the last cell of the one before is sent; the copy path reads the source
// track through the store's read port one row ahead of the cell being sent.
// The track store is not cleared after reset; a copy uses only tracks already
// written. Words after the last cell of the last pattern are taken and dropped.
`default_nettype none

`include "packed_track_pattern_unpacker_macros.svh"

module packed_track_pattern_unpacker
	import ptpu_pkg::*;
#(
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// input beats
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_W-1:0]    packed_word,
	// output beats
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    cell_res,
	output logic [OUT_PAT_W-1:0] pattern_index,
	output logic [VOICE_W-1:0]   voice,
	output logic [ROW_W-1:0]     row,
	output logic                 last,
	output logic                 bad_ref,
	output logic                 done_res
);

	localparam int TRACKS  = MAX_PATTERNS * VOICES;
	localparam int TRACK_W = $clog2(TRACKS);
	localparam int DEPTH   = TRACKS * ROWS_PER_TRACK;
	localparam int ADDR_W  = TRACK_W + ROW_W;
	localparam logic [PAT_W:0]   MAX_P      = (PAT_W+1)'(MAX_PATTERNS);
	localparam logic [PAT_W-1:0] PAT_CLAMP  = PAT_W'(MAX_PATTERNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS_PER_TRACK - 1);
	localparam logic [VOICE_W-1:0] VOICE_LAST = VOICE_W'(VOICES - 1);
	localparam logic [ROW_W:0]   ROWS_FULL  = (ROW_W+1)'(ROWS_PER_TRACK);

	ptpu_state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic [PAT_W-1:0]   pat_q;
	logic [VOICE_W-1:0] voice_q;
	logic [ROW_W-1:0]   row_q;
	logic [TW_W-1:0]    tw_q;
	logic               fin_q;

	logic [WORD_W-1:0]  val_q;
	logic [ROW_W:0]     rem_q;
	logic               ok_q;
	logic [TRACK_W-1:0] src_q;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    cell_q;
	logic [OUT_PAT_W-1:0] opat_q;
	logic [VOICE_W-1:0]   ovoice_q;
	logic [ROW_W-1:0]     orow_q;
	logic                 olast_q;
	logic                 obad_q;
	logic                 odone_q;

	logic               cfg_wr;
	logic               cfg_hit;
	logic               in_acc;
	logic               take;
	logic [15:0]        word_hi;
	logic               is_copy;
	logic               is_note;
	logic [SRC_W-1:0]   src_full;
	logic               ok_in;
	logic [8:0]         run_cnt;
	logic [ROW_W:0]     row_rem;
	logic [ROW_W:0]     cnt_in;
	logic [PAT_W:0]     eff;
	logic [PAT_W:0]     pnext;
	logic               track_end;
	logic               voice_last;
	logic               done_c;
	logic               out_free;
	logic               emit;
	logic [WORD_W-1:0]  cell_v;
	logic               bad_v;
	logic               last_v;
	logic [PAT_W+VOICE_W-1:0] cur_trk;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_hit = (paddr[PADDR_W-1:2] == REG_PATTERN_COUNT);
	assign prdata  = cfg_hit ? PDATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cfg_wr && cfg_hit) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	// word decode
	assign word_hi  = packed_word[31:16];
	assign is_copy  = (word_hi == HI_COPY);
	assign is_note  = (word_hi < HI_RUN_MIN);
	assign src_full = packed_word[15:2];
	assign ok_in    = (src_full < SRC_W'(tw_q));
	assign run_cnt  = {1'b0, packed_word[7:0]} + 9'd1;
	assign row_rem  = ROWS_FULL - {1'b0, row_q};
	assign cnt_in   = (run_cnt > 9'(row_rem)) ? row_rem : run_cnt[ROW_W:0];

	// effective pattern count and end-of-track conditions
	always_comb begin
		eff = {1'b0, count_q};
		if (eff == '0) begin
			eff = (PAT_W+1)'(1);
		end
		if (eff > MAX_P) begin
			eff = MAX_P;
		end
	end

	assign pnext      = {1'b0, pat_q} + (PAT_W+1)'(1);
	assign track_end  = (row_q == ROW_LAST);
	assign voice_last = (voice_q == VOICE_LAST);
	assign done_c     = track_end & voice_last & (pnext >= eff);
	assign out_free   = ~out_valid_q | ~out_stall;
	assign cur_trk    = {pat_q, voice_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !fin_q) begin
					state_d = is_copy ? ST_COPY : ST_RUN;
				end
			end
			ST_RUN: begin
				if (emit && rem_q == (ROW_W+1)'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_COPY: begin
				if (emit && track_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		emit     = 1'b0;
		cell_v   = val_q;
		bad_v    = 1'b0;
		last_v   = (rem_q == (ROW_W+1)'(1));
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RUN: begin
				emit = out_free;
			end
			ST_COPY: begin
				emit   = out_free;
				cell_v = ok_q ? ram_rdata : '0;
				bad_v  = ~ok_q;
				last_v = track_end;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_acc = in_valid & ~in_stall;
	assign take   = in_acc & ~fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (take) begin
			val_q <= is_note ? packed_word : '0;
			rem_q <= is_note ? (ROW_W+1)'(1) : cnt_in;
			ok_q  <= ok_in;
			src_q <= src_full[TRACK_W-1:0];
		end else if (emit) begin
			rem_q <= rem_q - (ROW_W+1)'(1);
		end
	end

	// position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= '0;
			voice_q <= '0;
			row_q   <= '0;
			tw_q    <= '0;
			fin_q   <= 1'b0;
		end else if (emit) begin
			row_q <= row_q + ROW_W'(1);
			if (track_end) begin
				if (tw_q != TW_MAX) begin
					tw_q <= tw_q + TW_W'(1);
				end
				if (voice_last) begin
					voice_q <= '0;
					if (pnext >= MAX_P) begin
						pat_q <= PAT_CLAMP;
					end else begin
						pat_q <= pnext[PAT_W-1:0];
					end
					if (pnext >= eff || pnext >= MAX_P) begin
						fin_q <= 1'b1;
					end
				end else begin
					voice_q <= voice_q + VOICE_W'(1);
				end
			end
		end
	end

	// track store, source row fetched one cell ahead
	assign ram_re    = (take & is_copy) | (emit & (state_q == ST_COPY) & ~track_end);
	assign ram_raddr = (state_q == ST_IDLE) ? {src_full[TRACK_W-1:0], row_q}
	                                        : {src_q, row_q + ROW_W'(1)};

	ptpu_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (emit),
		.waddr ({cur_trk[TRACK_W-1:0], row_q}),
		.wdata (cell_v),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cell_q   <= cell_v;
			opat_q   <= pat_q[OUT_PAT_W-1:0];
			ovoice_q <= voice_q;
			orow_q   <= row_q;
			olast_q  <= last_v;
			obad_q   <= bad_v;
			odone_q  <= done_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_res      = cell_q;
	assign pattern_index = opat_q;
	assign voice         = ovoice_q;
	assign row           = orow_q;
	assign last          = olast_q;
	assign bad_ref       = obad_q;
	assign done_res      = odone_q;

	// checks
	`PTPU_ASSERT_IMP(a_done_is_last, out_valid && done_res, last)
	`PTPU_ASSERT_IMP(a_track_end_is_last, out_valid && row == ROW_LAST, last)
	`PTPU_ASSERT_IMP(a_bad_ref_zero, out_valid && bad_ref, cell_res == '0)
	`PTPU_ASSERT_NXT(a_done_finishes, emit && done_c, fin_q)

endmodule

`default_nettype wire
